// ----- sv/bsb_pkg.sv -----
// shared types and constants for the bidirectional bubble sort block
// used by bsb_cell and bubble_sort_bidirectional; no dependencies
package bsb_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] bsb_value_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the incoming value in sorted position
        logic shift;    // move every entry one cell toward the head
    } bsb_op_t;

endpackage

// ----- sv/bsb_cell.sv -----
// one cell of the insertion chain: holds one entry and its valid bit
// depends on bsb_pkg
module bsb_cell
    import bsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bsb_op_t    op,
    input  logic       descending,
    input  bsb_value_t new_value,
    input  bsb_value_t prev_value,
    input  logic       prev_valid,
    input  logic       prev_ahead,
    input  bsb_value_t next_value,
    input  logic       next_valid,
    output bsb_value_t value,
    output logic       valid,
    output logic       ahead
);

    bsb_value_t value_reg;
    bsb_value_t value_next;
    logic       valid_reg;
    logic       valid_next;

    // strict compare keeps equal values in arrival order
    always_comb
    begin
        if (!valid_reg)
        begin
            ahead = 1'b1;
        end
        else if (descending)
        begin
            ahead = new_value > value_reg;
        end
        else
        begin
            ahead = new_value < value_reg;
        end
    end

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (op.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (op.insert)
        begin
            if (prev_ahead)
            begin
                // the new value lands above this cell, entry moves down
                value_next = prev_value;
                valid_next = prev_valid;
            end
            else if (ahead)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ----- sv/bubble_sort_bidirectional.sv -----
// load: one input per cycle; each value that fits is inserted in sorted position on arrival
// emit: once the last-marked input has set the state to emit, results leave the head cell
// through the output register, one per cycle while m_tready is high
// the chain of DEPTH cells sets capacity; the next list is taken once the final value has left
// the chain, while the last result may still wait in the output register
// rst_n (async, active low) empties the chain, clears counters, flags and the order register
module bubble_sort_bidirectional
    import bsb_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    input  logic               s_tlast,   // is_last
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,   // [31:0] value_res
    output logic               m_tlast,   // is_last_res
    output logic               m_tuser,   // [0] dropped
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data   // descending
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    typedef enum logic
    {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   remain_reg;
    logic               overflow_reg;
    logic               batch_drop_reg;
    logic               descending_reg;
    logic               m_tvalid_reg;
    logic [VALUE_W-1:0] m_tdata_reg;
    logic               m_tlast_reg;
    logic               m_tuser_reg;

    bsb_op_t            op;
    bsb_value_t         cell_value [DEPTH];
    logic               cell_valid [DEPTH];
    logic               cell_ahead [DEPTH];

    logic               in_xact;
    logic               has_room;
    logic               out_load;

    assign s_tready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign in_xact   = s_tvalid && s_tready;
    assign has_room  = count_reg < CNT_W'(DEPTH);
    assign out_load  = (state_reg == ST_EMIT) && (remain_reg != '0)
                       && (!m_tvalid_reg || m_tready);

    assign op.insert = in_xact && has_room;
    assign op.shift  = out_load;

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            bsb_value_t prev_value;
            logic       prev_valid;
            logic       prev_ahead;
            bsb_value_t next_value;
            logic       next_valid;

            if (i == 0)
            begin : g_head
                assign prev_value = '0;
                assign prev_valid = 1'b0;
                assign prev_ahead = 1'b0;
            end
            else
            begin : g_body
                assign prev_value = cell_value[i-1];
                assign prev_valid = cell_valid[i-1];
                assign prev_ahead = cell_ahead[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign next_value = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_inner
                assign next_value = cell_value[i+1];
                assign next_valid = cell_valid[i+1];
            end

            bsb_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .descending (descending_reg),
                .new_value  (bsb_value_t'(s_tdata)),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .prev_ahead (prev_ahead),
                .next_value (next_value),
                .next_valid (next_valid),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .ahead      (cell_ahead[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            remain_reg     <= '0;
            overflow_reg   <= 1'b0;
            batch_drop_reg <= 1'b0;
            descending_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tlast_reg    <= 1'b0;
            m_tuser_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                descending_reg <= cfg_data;
            end

            // output register drains independently of loading
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= cell_value[0];
                m_tlast_reg  <= (remain_reg == CNT_W'(1));
                m_tuser_reg  <= batch_drop_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_xact)
                    begin
                        if (s_tlast)
                        begin
                            state_reg      <= ST_EMIT;
                            remain_reg     <= has_room ? count_reg + CNT_W'(1) : count_reg;
                            batch_drop_reg <= overflow_reg || !has_room;
                            count_reg      <= '0;
                            overflow_reg   <= 1'b0;
                        end
                        else if (has_room)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        remain_reg <= remain_reg - CNT_W'(1);
                        if (remain_reg == CNT_W'(1))
                        begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- sv/bsb_checker.sv -----
// port-level checks for bubble_sort_bidirectional, attached with bind
// depends on bsb_pkg and the top level's ports
module bsb_checker
    import bsb_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [VALUE_W-1:0] m_tdata,
    input logic               m_tlast,
    input logic               m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
    else $error("stalled result changed");

    // input closes while a list is being emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input accepted right after end of list");

    // more results pending, so input stays closed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
    else $error("input reopened before the list was emitted");

    // dropped flag is the same on every result of one list
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> $stable(m_tuser))
    else $error("dropped flag changed within a list");

endmodule

bind bubble_sort_bidirectional bsb_checker u_bsb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
